// ===== design/jevm_pkg.sv =====
`timescale 1ns / 1ps

package jevm_pkg;

   localparam int JOINTS = 29;
   localparam int GROUPS = 5;

   localparam int MUL_W = 32;

   localparam logic [23:0] DT_RESET   = 24'd33554;
   localparam logic [16:0] RATE_RESET = 17'd500;

   // csr word index, taken from paddr[2]
   localparam logic REG_DT   = 1'b0;
   localparam logic REG_RATE = 1'b1;

   localparam logic [47:0] MAX48  = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] ACC_HI = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] ACC_LO = 48'h8000_0000_0000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PWR,
      ST_ACC,
      ST_HI,
      ST_LO,
      ST_UPD
   } state_type;

   // operands of the shared multiplier
   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_op_type;

   function automatic logic [2:0] group_of(input logic [4:0] joint);
      logic [2:0] g;
      unique case (joint)
         5'd4, 5'd5, 5'd10, 5'd11:                   g = 3'd1;
         5'd12, 5'd13, 5'd14:                         g = 3'd2;
         5'd15, 5'd16, 5'd17, 5'd18,
         5'd22, 5'd23, 5'd24, 5'd25:                  g = 3'd3;
         5'd19, 5'd20, 5'd21, 5'd26, 5'd27, 5'd28:    g = 3'd4;
         default:                                     g = 3'd0;
      endcase
      return g;
   endfunction

endpackage

// ===== design/jevm_mul.sv =====
`timescale 1ns / 1ps

module jevm_mul
   import jevm_pkg::*;
(
   input  logic                 clock,
   input  mul_op_type           op,
   output logic [2*MUL_W-1:0]   prod_ff
);

   logic [2*MUL_W-1:0] prod_in;

   // unsigned product, registered every cycle
   assign prod_in = (2*MUL_W)'(op.a) * (2*MUL_W)'(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/joint_energy_vibration_meter.sv =====
`timescale 1ns / 1ps
// a live sample runs ST_PWR, ST_ACC, ST_HI, ST_LO, ST_UPD; ST_UPD puts its word
// on rsp once the output register is free; the next sample waits for four
// passes through the single shared 32x32 multiplier and the read-modify-write
// of the stores; a dead, bad-joint or bad-robot sample is consumed in ST_IDLE
// with no word; reset: synchronous, active high; afterwards a clearing pass of
// ROBOTS*29 entries (1856 by default) zeroes the stores while req_ready is low

module joint_energy_vibration_meter
   import jevm_pkg::*;
#(
   parameter int ROBOTS = 64
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  logic [5:0]   req_robot_index,
   input  logic [4:0]   req_joint_index,
   input  logic [31:0]  req_joint_velocity,
   input  logic [31:0]  req_joint_torque,
   input  logic         req_robot_alive,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_group_index,
   output logic [47:0]  rsp_energy_total,
   output logic [47:0]  rsp_vibration_total,

   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int JDEPTH = ROBOTS * JOINTS;
   localparam int GDEPTH = ROBOTS * GROUPS;
   localparam int JAW    = $clog2(JDEPTH);
   localparam int GAW    = $clog2(GDEPTH);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [23:0] dt_ff;
   logic [16:0] rate_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= DT_RESET;
         rate_ff <= RATE_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_DT:   dt_ff   <= pwdata[23:0];
            REG_RATE: rate_ff <= pwdata[16:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_DT:   prdata = {8'd0, dt_ff};
         REG_RATE: prdata = {15'd0, rate_ff};
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer state and control
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   logic      req_fire;
   logic      item_ok;
   logic      out_free;
   logic      upd_fire;
   logic      clr_last;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [JAW-1:0] clr_ff, clr_in;

   // word leaves the output register or the register is empty
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign clr_last = (clr_ff == JAW'(JDEPTH - 1));

   // sample is processed only for a live robot and an in-range index
   assign item_ok = req_robot_alive
                 && (req_joint_index < 5'(JOINTS))
                 && (16'(req_robot_index) < 16'(ROBOTS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid && item_ok) state_in = ST_PWR;
         ST_PWR:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_HI;
         ST_HI:    state_in = ST_LO;
         ST_LO:    state_in = ST_UPD;
         ST_UPD:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------
   logic [31:0]  vel_ff;
   logic [31:0]  tq_ff;
   logic [2:0]   grp_ff;
   logic [JAW-1:0] jaddr_ff;
   logic [GAW-1:0] gaddr_ff;

   logic [15:0]  jaddr_full;
   logic [15:0]  gaddr_full;
   logic [2:0]   req_grp;

   logic [79:0]  jrd_ff;       // {previous acceleration, previous velocity}
   logic [95:0]  grd_ff;       // {vibration total, energy total}

   logic         dneg_ff;
   logic [31:0]  dmag_ff;
   logic [63:0]  power_ff;
   logic [47:0]  acc_ff, acc_in;
   logic [53:0]  hi_ff;
   logic [47:0]  vinc_ff, vinc_in;

   logic [2*MUL_W-1:0] prod_ff;
   mul_op_type         mul_op;

   logic [32:0]  vdiff;
   logic [32:0]  vdiff_mag;
   logic [31:0]  tq_mag;
   logic [31:0]  vel_mag;
   logic [48:0]  amag;
   logic [48:0]  adiff;
   logic [48:0]  adiff_mag;
   logic [54:0]  esum;
   logic [46:0]  einc;
   logic [48:0]  etot_sum;
   logic [48:0]  vtot_sum;
   logic [47:0]  etot_in;
   logic [47:0]  vtot_in;

   assign req_grp    = group_of(req_joint_index);
   assign jaddr_full = 16'(req_robot_index) * 16'(JOINTS) + 16'(req_joint_index);
   assign gaddr_full = 16'(req_robot_index) * 16'(GROUPS) + 16'(req_grp);

   // magnitudes for the power product
   assign tq_mag  = tq_ff[31]  ? 32'(-tq_ff)  : tq_ff;
   assign vel_mag = vel_ff[31] ? 32'(-vel_ff) : vel_ff;

   // velocity change against the stored value; read data is valid in ST_PWR
   assign vdiff     = {vel_ff[31], vel_ff} - {jrd_ff[31], jrd_ff[31:0]};
   assign vdiff_mag = vdiff[32] ? 33'(-vdiff) : vdiff;

   // signed acceleration from the rate product, clamped to 48 bits
   assign amag = prod_ff[48:0];
   always_comb begin
      if (dneg_ff) begin
         acc_in = (amag > 49'({1'b0, ACC_LO})) ? ACC_LO : 48'(-amag);
      end else begin
         acc_in = (amag > 49'(ACC_HI)) ? ACC_HI : amag[47:0];
      end
   end

   // change of acceleration
   assign adiff     = {acc_ff[47], acc_ff} - {jrd_ff[79], jrd_ff[79:32]};
   assign adiff_mag = adiff[48] ? 49'(-adiff) : adiff;
   assign vinc_in   = adiff_mag[47:0];

   // energy increment: (hi + lo >> 32) >> 8, with lo on the multiplier output
   assign esum = 55'(hi_ff) + 55'(prod_ff[63:32]);
   assign einc = esum[54:8];

   // saturating totals
   assign etot_sum = 49'(grd_ff[47:0]) + 49'(einc);
   assign vtot_sum = 49'(grd_ff[95:48]) + 49'(vinc_ff);
   assign etot_in  = etot_sum[48] ? MAX48 : etot_sum[47:0];
   assign vtot_in  = vtot_sum[48] ? MAX48 : vtot_sum[47:0];

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      upd_fire  = 1'b0;
      clr_in    = clr_ff;
      mul_op.a  = tq_mag;
      mul_op.b  = vel_mag;
      unique case (state_ff)
         ST_CLEAR: clr_in = clr_last ? '0 : clr_ff + 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_PWR: begin
            mul_op.a = tq_mag;
            mul_op.b = vel_mag;
         end
         ST_ACC: begin
            mul_op.a = dmag_ff;
            mul_op.b = 32'(rate_ff);
         end
         ST_HI: begin
            mul_op.a = power_ff[63:32];
            mul_op.b = 32'(dt_ff);
         end
         ST_LO: begin
            mul_op.a = power_ff[31:0];
            mul_op.b = 32'(dt_ff);
         end
         // keep the low product on the multiplier output while the word waits
         ST_UPD: begin
            mul_op.a = power_ff[31:0];
            mul_op.b = 32'(dt_ff);
            upd_fire = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // output word valid: set on update, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample capture and stage registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         vel_ff   <= req_joint_velocity;
         tq_ff    <= req_joint_torque;
         grp_ff   <= req_grp;
         jaddr_ff <= jaddr_full[JAW-1:0];
         gaddr_ff <= gaddr_full[GAW-1:0];
      end
      if (state_ff == ST_PWR) begin
         dneg_ff <= vdiff[32];
         dmag_ff <= vdiff_mag[31:0];
      end
      if (state_ff == ST_ACC) begin
         power_ff <= prod_ff;
      end
      if (state_ff == ST_HI) begin
         acc_ff <= acc_in;
      end
      if (state_ff == ST_LO) begin
         hi_ff   <= prod_ff[53:0];
         vinc_ff <= vinc_in;
      end
   end

   jevm_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod_ff)
   );

   // ---------------------------------------------------------------
   // stores: per-joint history and per-group totals
   // ---------------------------------------------------------------
   logic [79:0] joint_mem [JDEPTH];
   logic [95:0] group_mem [GDEPTH];

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         joint_mem[clr_ff] <= '0;
      end else if (upd_fire) begin
         joint_mem[jaddr_ff] <= {acc_ff, vel_ff};
      end
      if (req_fire) begin
         jrd_ff <= joint_mem[jaddr_full[JAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         if (16'(clr_ff) < 16'(GDEPTH)) begin
            group_mem[clr_ff[GAW-1:0]] <= '0;
         end
      end else if (upd_fire) begin
         group_mem[gaddr_ff] <= {vtot_in, etot_in};
      end
      if (req_fire) begin
         grd_ff <= group_mem[gaddr_full[GAW-1:0]];
      end
   end

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   logic [2:0]  out_grp_ff;
   logic [47:0] out_etot_ff;
   logic [47:0] out_vtot_ff;

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         out_grp_ff  <= grp_ff;
         out_etot_ff <= etot_in;
         out_vtot_ff <= vtot_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_group_index     = out_grp_ff;
   assign rsp_energy_total    = out_etot_ff;
   assign rsp_vibration_total = out_vtot_ff;

endmodule
